/* sv/fcg_pkg.sv */
// shared constants and types of the four-corner gradient pixel block
// no dependencies; read by the interfaces, the divider and the top level
package fcg_pkg;

	localparam int PIX_W       = 12;
	localparam int CHAN_W      = 8;
	localparam int LANES       = 4;
	localparam int COLOR_W     = CHAN_W * LANES;
	localparam int CFG_DIM_W   = 13;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int DEF_MAX_DIM = 4096;

	localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = CFG_DIM_W'(1920);
	localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = CFG_DIM_W'(1080);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLOR_TL = 3'd0,
		REG_COLOR_BL = 3'd1,
		REG_COLOR_TR = 3'd2,
		REG_COLOR_BR = 3'd3,
		REG_WIDTH    = 3'd4,
		REG_HEIGHT   = 3'd5
	} cfg_reg_t;

endpackage

/* sv/fcg_ifs.sv */
// valid/ready channel interfaces: pixel coordinate, colour result, register write
// depends on fcg_pkg for the payload widths
interface fcg_pixel_if;
	logic                       valid;
	logic                       ready;
	logic [fcg_pkg::PIX_W-1:0]  pixel_x;
	logic [fcg_pkg::PIX_W-1:0]  pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface fcg_color_if;
	logic                       valid;
	logic                       ready;
	logic [fcg_pkg::CHAN_W-1:0] chan_zero;
	logic [fcg_pkg::CHAN_W-1:0] chan_one;
	logic [fcg_pkg::CHAN_W-1:0] chan_two;
	logic [fcg_pkg::CHAN_W-1:0] chan_three;

	modport source (output valid, output chan_zero, output chan_one, output chan_two,
		output chan_three, input ready);
	modport sink   (input valid, input chan_zero, input chan_one, input chan_two,
		input chan_three, output ready);
endinterface

interface fcg_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [fcg_pkg::CFG_IDX_W-1:0]  index;
	logic [fcg_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/fcg_div_pipe.sv */
// pipelined restoring divider, one quotient bit per stage, four lanes sharing a divisor
// depends on fcg_pkg; quotient must fit in CHAN_W bits (numerator below divisor * 256)
module fcg_div_pipe #(
	parameter int NUM_W = 34,
	parameter int DEN_W = 26
) (
	input  logic                                         clk,
	input  logic [fcg_pkg::CHAN_W-1:0]                   en,
	input  logic [fcg_pkg::LANES-1:0][NUM_W-1:0]         num,
	input  logic [DEN_W-1:0]                             den,
	output logic [fcg_pkg::LANES-1:0][fcg_pkg::CHAN_W-1:0] quo
);

	localparam int STEPS = fcg_pkg::CHAN_W;
	localparam int LANES = fcg_pkg::LANES;

	logic [NUM_W-1:0]          rem_s [STEPS][LANES];
	logic [fcg_pkg::CHAN_W-1:0] quo_s [STEPS][LANES];

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		for (genvar k = 0; k < LANES; k++) begin : g_lane
			logic [NUM_W-1:0]           r_in;
			logic [fcg_pkg::CHAN_W-1:0] q_in;
			logic [NUM_W-1:0]           dsh;
			logic                       take;

			if (j == 0) begin : g_first
				assign r_in = num[k];
				assign q_in = '0;
			end else begin : g_next
				assign r_in = rem_s[j-1][k];
				assign q_in = quo_s[j-1][k];
			end

			// divisor aligned to this stage's quotient bit
			assign dsh  = NUM_W'(den) << (STEPS - 1 - j);
			assign take = (r_in >= dsh);

			always_ff @(posedge clk) begin
				if (en[j]) begin
					rem_s[j][k] <= take ? (r_in - dsh) : r_in;
					quo_s[j][k] <= {q_in[fcg_pkg::CHAN_W-2:0], take};
				end
			end
		end
	end

	for (genvar k = 0; k < LANES; k++) begin : g_out
		assign quo[k] = quo_s[STEPS-1][k];
	end

endmodule

/* sv/four_corner_gradient_pixel.sv */
// top level of the four-corner gradient pixel block: registers, pipeline control, arithmetic
// depends on fcg_pkg, the channel interfaces in fcg_ifs and the divider fcg_div_pipe
//
// Takes one pixel coordinate per transfer and returns the four 8-bit channels of a
// bilinear blend of four corner colours, each channel being
// floor(((TL*(w-x)+TR*x)*(h-y)+(BL*(w-x)+BR*x)*y)/(w*h)) in exact integer arithmetic.
// A width or height of zero is taken as one, one above MAX_DIM as MAX_DIM, and a
// coordinate beyond the frame is pinned to the right or bottom edge. The block is an
// eleven-stage pipeline: one pixel enters and one leaves every clock cycle while the output
// is not stalled. The divider resolves one quotient bit per stage over eight stages,
// behind a clamp stage and two multiply stages. Valid bits travel with the data and empty
// stages close up under back-pressure, so the input stays ready while any stage holds a
// bubble. Register writes take effect at once and are meant for when no pixel is in flight.
module four_corner_gradient_pixel #(
	parameter int MAX_DIM = fcg_pkg::DEF_MAX_DIM
) (
	input  logic         clk,
	input  logic         arst_n,
	fcg_pixel_if.sink    pixel,
	fcg_color_if.source  color,
	fcg_cfg_if.sink      cfg
);

	localparam int CHAN_W = fcg_pkg::CHAN_W;
	localparam int LANES  = fcg_pkg::LANES;
	// width of an effective dimension
	localparam int DW     = $clog2(MAX_DIM + 1);
	// width for comparing register and coordinate values against the clamp limits
	localparam int EW     = (DW > fcg_pkg::CFG_DIM_W) ? DW : fcg_pkg::CFG_DIM_W;
	// one weighted row sum, at most 255 * w
	localparam int TW     = CHAN_W + DW;
	// full numerator, at most 255 * w * h
	localparam int NW     = CHAN_W + 2 * DW;
	localparam int DENW   = 2 * DW;
	// clamp, two multiply stages, then one stage per quotient bit
	localparam int STAGES = 3 + CHAN_W;

	// configuration registers
	logic [fcg_pkg::COLOR_W-1:0]   color_tl_q;
	logic [fcg_pkg::COLOR_W-1:0]   color_bl_q;
	logic [fcg_pkg::COLOR_W-1:0]   color_tr_q;
	logic [fcg_pkg::COLOR_W-1:0]   color_br_q;
	logic [fcg_pkg::CFG_DIM_W-1:0] width_q;
	logic [fcg_pkg::CFG_DIM_W-1:0] height_q;

	// effective dimensions and the shared divisor
	logic [EW-1:0]   width_ext;
	logic [EW-1:0]   height_ext;
	logic [DW-1:0]   dim_w;
	logic [DW-1:0]   dim_h;
	logic [DENW-1:0] den_q;

	// pipeline control
	logic [STAGES-1:0] vld_s;
	logic [STAGES-1:0] en;

	// stage 1: clamped coordinates and their complements
	logic [EW-1:0] x_ext;
	logic [EW-1:0] y_ext;
	logic [DW-1:0] x_cl;
	logic [DW-1:0] y_cl;
	logic [DW-1:0] x_s1;
	logic [DW-1:0] wmx_s1;
	logic [DW-1:0] y_s1;
	logic [DW-1:0] hmy_s1;

	// stage 2: top and bottom row blends per channel
	logic [LANES-1:0][TW-1:0] top_s2;
	logic [LANES-1:0][TW-1:0] bot_s2;
	logic [DW-1:0]            y_s2;
	logic [DW-1:0]            hmy_s2;

	// stage 3: numerators
	logic [LANES-1:0][NW-1:0] num_s3;

	logic [LANES-1:0][CHAN_W-1:0] quo;

	// register writes, always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_tl_q <= '0;
			color_bl_q <= '0;
			color_tr_q <= '0;
			color_br_q <= '0;
			width_q    <= fcg_pkg::WIDTH_RESET;
			height_q   <= fcg_pkg::HEIGHT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				fcg_pkg::REG_COLOR_TL: color_tl_q <= cfg.data[fcg_pkg::COLOR_W-1:0];
				fcg_pkg::REG_COLOR_BL: color_bl_q <= cfg.data[fcg_pkg::COLOR_W-1:0];
				fcg_pkg::REG_COLOR_TR: color_tr_q <= cfg.data[fcg_pkg::COLOR_W-1:0];
				fcg_pkg::REG_COLOR_BR: color_br_q <= cfg.data[fcg_pkg::COLOR_W-1:0];
				fcg_pkg::REG_WIDTH:    width_q    <= cfg.data[fcg_pkg::CFG_DIM_W-1:0];
				fcg_pkg::REG_HEIGHT:   height_q   <= cfg.data[fcg_pkg::CFG_DIM_W-1:0];
				// writes beyond the register list are dropped
				default: ;
			endcase
		end
	end

	// zero taken as one, oversize taken as the limit
	assign width_ext  = EW'(width_q);
	assign height_ext = EW'(height_q);

	always_comb begin
		priority if (width_ext == '0) begin
			dim_w = DW'(1);
		end else if (width_ext > EW'(MAX_DIM)) begin
			dim_w = DW'(MAX_DIM);
		end else begin
			dim_w = DW'(width_ext);
		end
	end

	always_comb begin
		priority if (height_ext == '0) begin
			dim_h = DW'(1);
		end else if (height_ext > EW'(MAX_DIM)) begin
			dim_h = DW'(MAX_DIM);
		end else begin
			dim_h = DW'(height_ext);
		end
	end

	// divisor only changes with the registers, so it is settled long before the divider
	always_ff @(posedge clk) begin
		den_q <= DENW'(dim_w) * DENW'(dim_h);
	end

	// a stage moves when it is empty or the one after it moves
	for (genvar i = 0; i < STAGES - 1; i++) begin : g_en
		assign en[i] = !vld_s[i] || en[i+1];
	end
	assign en[STAGES-1] = !vld_s[STAGES-1] || color.ready;

	assign pixel.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en[0]) begin
			vld_s[0] <= pixel.valid;
		end
	end

	for (genvar i = 1; i < STAGES; i++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en[i]) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// stage 1: pin coordinates beyond the frame to the far edge
	assign x_ext = EW'(pixel.pixel_x);
	assign y_ext = EW'(pixel.pixel_y);
	assign x_cl  = (x_ext > EW'(dim_w)) ? dim_w : DW'(x_ext);
	assign y_cl  = (y_ext > EW'(dim_h)) ? dim_h : DW'(y_ext);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s1   <= x_cl;
			wmx_s1 <= dim_w - x_cl;
			y_s1   <= y_cl;
			hmy_s1 <= dim_h - y_cl;
		end
	end

	// stage 2: horizontal blend along the top and bottom edges
	for (genvar k = 0; k < LANES; k++) begin : g_row
		logic [CHAN_W-1:0] tl;
		logic [CHAN_W-1:0] tr;
		logic [CHAN_W-1:0] bl;
		logic [CHAN_W-1:0] br;

		assign tl = color_tl_q[k*CHAN_W +: CHAN_W];
		assign tr = color_tr_q[k*CHAN_W +: CHAN_W];
		assign bl = color_bl_q[k*CHAN_W +: CHAN_W];
		assign br = color_br_q[k*CHAN_W +: CHAN_W];

		always_ff @(posedge clk) begin
			if (en[1]) begin
				top_s2[k] <= TW'(tl) * TW'(wmx_s1) + TW'(tr) * TW'(x_s1);
				bot_s2[k] <= TW'(bl) * TW'(wmx_s1) + TW'(br) * TW'(x_s1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			y_s2   <= y_s1;
			hmy_s2 <= hmy_s1;
		end
	end

	// stage 3: vertical blend of the two row sums
	for (genvar k = 0; k < LANES; k++) begin : g_col
		always_ff @(posedge clk) begin
			if (en[2]) begin
				num_s3[k] <= NW'(top_s2[k]) * NW'(hmy_s2) + NW'(bot_s2[k]) * NW'(y_s2);
			end
		end
	end

	// stages 4 to 11: numerator fits below 256 times the divisor, so no saturation is needed
	fcg_div_pipe #(
		.NUM_W (NW),
		.DEN_W (DENW)
	) u_div (
		.clk (clk),
		.en  (en[STAGES-1:3]),
		.num (num_s3),
		.den (den_q),
		.quo (quo)
	);

	assign color.valid      = vld_s[STAGES-1];
	assign color.chan_zero  = quo[0];
	assign color.chan_one   = quo[1];
	assign color.chan_two   = quo[2];
	assign color.chan_three = quo[3];

endmodule
